// ===== sv/datm_pkg.sv =====
// shared types and constants for the daily alarm table matcher
// no dependencies
package datm_pkg;

  localparam int ALARM_SLOTS = 6;
  localparam int SCAN_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam logic [SCAN_W-1:0] LAST_SLOT = SCAN_W'(ALARM_SLOTS - 1);
  localparam logic [3:0] SLOT_COUNT = 4'(ALARM_SLOTS);

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] day_of_month;
    logic [2:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic [5:0] fired_mask;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } path_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       slot_free;
    logic       scan_last;
  } path_stat_t;

endpackage

// ===== sv/datm_ctrl.sv =====
// controller state machine for the alarm table matcher
// depends on datm_pkg
module datm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  datm_pkg::path_stat_t stat,
  output datm_pkg::path_cmd_t  cmd,
  output logic                busy,
  output logic                done
);

  datm_pkg::state_t state, state_next;
  logic finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= datm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (stat.kind)
      datm_pkg::KIND_ADD:  finish = stat.slot_free | stat.scan_last;
      datm_pkg::KIND_TICK: finish = stat.scan_last;
      default:             finish = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      datm_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = datm_pkg::S_EXEC;
        end
      end
      datm_pkg::S_EXEC: begin
        cmd.step = 1'b1;
        if (finish) begin
          state_next = datm_pkg::S_REPORT;
        end
      end
      datm_pkg::S_REPORT: begin
        done = 1'b1;
        state_next = datm_pkg::S_IDLE;
      end
      default: begin
        state_next = datm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/datm_path.sv =====
// datapath for the alarm table matcher: slot table, scan counter, result register
// depends on datm_pkg
module datm_path (
  input  logic                 clk,
  input  logic                 rst,
  input  datm_pkg::req_t       request,
  input  datm_pkg::path_cmd_t  cmd,
  output datm_pkg::path_stat_t stat,
  output datm_pkg::res_t       result
);

  logic                        slot_active [datm_pkg::ALARM_SLOTS];
  logic                        slot_fired  [datm_pkg::ALARM_SLOTS];
  logic [4:0]                  slot_hour   [datm_pkg::ALARM_SLOTS];
  logic [5:0]                  slot_minute [datm_pkg::ALARM_SLOTS];
  logic [4:0]                  last_day;
  datm_pkg::req_t              req;
  logic [datm_pkg::SCAN_W-1:0] scan_idx;
  logic [datm_pkg::SCAN_W-1:0] del_idx;
  logic                        del_ok;
  logic                        match;
  logic [7:0]                  fire_bit;

  assign del_idx  = req.slot_index[datm_pkg::SCAN_W-1:0];
  assign del_ok   = {1'b0, req.slot_index} < datm_pkg::SLOT_COUNT;
  assign match    = slot_active[scan_idx] && !slot_fired[scan_idx] &&
                    slot_hour[scan_idx] == req.hour && slot_minute[scan_idx] == req.minute;
  assign fire_bit = 8'd1 << scan_idx;

  assign stat.kind      = req.kind;
  assign stat.slot_free = !slot_active[scan_idx];
  assign stat.scan_last = scan_idx == datm_pkg::LAST_SLOT;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) begin
        slot_active[i] <= 1'b0;
        slot_fired[i]  <= 1'b0;
      end
      last_day <= 5'd0;
    end else if (cmd.load) begin
      if (request.kind == datm_pkg::KIND_TICK && request.day_of_month != last_day) begin
        for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) begin
          slot_fired[i] <= 1'b0;
        end
        last_day <= request.day_of_month;
      end
    end else if (cmd.step) begin
      case (req.kind)
        datm_pkg::KIND_ADD: begin
          if (!slot_active[scan_idx]) begin
            slot_active[scan_idx] <= 1'b1;
            slot_fired[scan_idx]  <= 1'b0;
          end
        end
        datm_pkg::KIND_DEL: begin
          if (del_ok) begin
            slot_active[del_idx] <= 1'b0;
            slot_fired[del_idx]  <= 1'b0;
          end
        end
        datm_pkg::KIND_TICK: begin
          if (match) begin
            slot_fired[scan_idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload: request copy, stored time, scan index, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= request;
      scan_idx <= '0;
      result   <= '0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
      case (req.kind)
        datm_pkg::KIND_ADD: begin
          if (!slot_active[scan_idx]) begin
            slot_hour[scan_idx]   <= req.hour;
            slot_minute[scan_idx] <= req.minute;
            result.slot           <= 3'(scan_idx);
          end else if (scan_idx == datm_pkg::LAST_SLOT) begin
            result.status <= datm_pkg::STATUS_FULL;
          end
        end
        datm_pkg::KIND_DEL: begin
          if (!del_ok) begin
            result.status <= datm_pkg::STATUS_BAD_INDEX;
          end
        end
        datm_pkg::KIND_TICK: begin
          if (match) begin
            result.fired_mask <= result.fired_mask | fire_bit[5:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/daily_alarm_table_matcher_unit.sv =====
// top level of the daily alarm table matcher
// depends on datm_pkg, datm_ctrl, datm_path
//
// one request channel and one result channel
// a request (kind, hour, minute, day_of_month, slot_index) is taken at a
// rising edge with start high and busy low; busy stays high until the
// result has been shown
// the result (status, slot, fired_mask) is held on result and marked by done,
// which is high for exactly one cycle; the receiver cannot stall it
// a tick or a full-table add scans the slots one per cycle, an add stops at
// the first free slot, a delete or an unused kind does no scan
// after the accepting edge the block scans in S_EXEC, then raises done in
// S_REPORT and returns to S_IDLE; a new request is not taken before the
// last result has been shown
// the slot scan goes through the one shared compare
// reset clears every slot, every fired-today mark and the stored day,
// and returns the block to idle
module daily_alarm_table_matcher_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  datm_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output datm_pkg::res_t result
);

  datm_pkg::path_cmd_t  cmd;
  datm_pkg::path_stat_t stat;

  datm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  datm_path u_path (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

// ===== sv/datm_checker.sv =====
// port-level checks for the daily alarm table matcher
// depends on datm_pkg; bound to daily_alarm_table_matcher_unit
module datm_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input datm_pkg::res_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result not a single strobe followed by idle");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.status != datm_pkg::STATUS_OK |->
      result.slot == 3'd0 && result.fired_mask == 6'd0)
    else $error("error result carries slot or mask");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status == datm_pkg::STATUS_OK ||
             result.status == datm_pkg::STATUS_FULL ||
             result.status == datm_pkg::STATUS_BAD_INDEX)
    else $error("unknown status code");

endmodule

bind daily_alarm_table_matcher_unit datm_checker u_datm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench for daily_alarm_table_matcher_unit: clocked driver and monitor, with a
// predictor that mirrors the alarm table and checks every result in order
// depends on datm_pkg and daily_alarm_table_matcher_unit
module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * datm_pkg::ALARM_SLOTS + 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  datm_pkg::req_t request = '0;
  logic busy;
  logic done;
  datm_pkg::res_t result;

  daily_alarm_table_matcher_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the alarm table
  logic       slot_on [datm_pkg::ALARM_SLOTS];
  logic [4:0] slot_hr [datm_pkg::ALARM_SLOTS];
  logic [5:0] slot_mn [datm_pkg::ALARM_SLOTS];
  logic       slot_fired [datm_pkg::ALARM_SLOTS];
  logic [4:0] prev_day;

  datm_pkg::req_t pending_requests[$];
  datm_pkg::res_t expected_results[$];
  logic [10:0] added_times[$];

  int sender_idle_pct = 24;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int alarms_fired = 0;
  int full_adds = 0;
  int bad_deletes = 0;
  int cycle_count = 0;
  int gen_day = 0;

  function automatic datm_pkg::req_t make_req(logic [1:0] kind, int hour, int minute,
                                              int day, int idx);
    datm_pkg::req_t r;
    r.kind = kind;
    r.hour = 5'(hour);
    r.minute = 6'(minute);
    r.day_of_month = 5'(day);
    r.slot_index = 3'(idx);
    return r;
  endfunction

  function automatic datm_pkg::res_t alarm_table_step(datm_pkg::req_t r);
    datm_pkg::res_t res;
    logic found;
    res = '0;
    found = 1'b0;
    case (r.kind)
      datm_pkg::KIND_ADD: begin
        for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found = 1'b1;
            slot_on[i] = 1'b1;
            slot_hr[i] = r.hour;
            slot_mn[i] = r.minute;
            slot_fired[i] = 1'b0;
            res.slot = 3'(i);
          end
        end
        if (!found) begin
          res.status = datm_pkg::STATUS_FULL;
          full_adds++;
        end
      end
      datm_pkg::KIND_DEL: begin
        if (int'(r.slot_index) >= datm_pkg::ALARM_SLOTS) begin
          res.status = datm_pkg::STATUS_BAD_INDEX;
          bad_deletes++;
        end else begin
          slot_on[r.slot_index] = 1'b0;
          slot_fired[r.slot_index] = 1'b0;
        end
      end
      datm_pkg::KIND_TICK: begin
        if (r.day_of_month != prev_day) begin
          for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) slot_fired[i] = 1'b0;
          prev_day = r.day_of_month;
        end
        for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) begin
          if (slot_on[i] && !slot_fired[i] && slot_hr[i] == r.hour &&
              slot_mn[i] == r.minute) begin
            slot_fired[i] = 1'b1;
            alarms_fired++;
            if (i < 6) res.fired_mask[i] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    error_count++;
  endtask

  task automatic queue_random(int count);
    int roll;
    int hr;
    int mn;
    int dy;
    int ix;
    logic [1:0] k;
    logic [10:0] t;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      hr = $urandom_range(0, 31);
      mn = $urandom_range(0, 63);
      dy = $urandom_range(0, 31);
      ix = $urandom_range(0, 7);
      if (roll < 25) begin
        k = datm_pkg::KIND_ADD;
        if ($urandom_range(0, 3) != 0) begin
          hr = $urandom_range(0, 23);
          mn = $urandom_range(0, 59);
        end
        added_times.push_back({5'(hr), 6'(mn)});
        if (added_times.size() > 8) void'(added_times.pop_front());
      end else if (roll < 50) begin
        k = datm_pkg::KIND_DEL;
      end else if (roll < 95) begin
        k = datm_pkg::KIND_TICK;
        if (added_times.size() != 0 && $urandom_range(0, 99) < 70) begin
          t = added_times[$urandom_range(0, added_times.size() - 1)];
          hr = int'(t[10:6]);
          mn = int'(t[5:0]);
        end
        if ($urandom_range(0, 6) == 0) gen_day = $urandom_range(0, 31);
        dy = gen_day;
      end else begin
        k = KIND_UNUSED;
      end
      pending_requests.push_back(make_req(k, hr, mn, dy, ix));
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alarm_table_step(request));
        requests_sent++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          request <= pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    datm_pkg::res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request waiting, status", -1, int'(result.status));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.status != want.status)
          report_mismatch("status", int'(want.status), int'(result.status));
        if (result.slot != want.slot)
          report_mismatch("slot", int'(want.slot), int'(result.slot));
        if (result.fired_mask != want.fired_mask)
          report_mismatch("fired_mask", int'(want.fired_mask), int'(result.fired_mask));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < datm_pkg::ALARM_SLOTS; i++) begin
      slot_on[i] = 1'b0;
      slot_hr[i] = '0;
      slot_mn[i] = '0;
      slot_fired[i] = 1'b0;
    end
    prev_day = '0;

    // directed part
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 0, 0, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 0, 0, 31, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 23, 59, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 31, 63, 31, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 12, 30, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 0, 0, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 5, 5, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 7, 7, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 0, 0, 0, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 0, 0, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 0, 0, 1, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 31, 63, 31, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_DEL, 31, 63, 31, 6));
    pending_requests.push_back(make_req(datm_pkg::KIND_DEL, 0, 0, 0, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_DEL, 0, 0, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_DEL, 0, 0, 0, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_ADD, 31, 0, 0, 0));
    pending_requests.push_back(make_req(KIND_UNUSED, 31, 63, 31, 7));
    pending_requests.push_back(make_req(datm_pkg::KIND_DEL, 0, 0, 0, 5));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 5, 5, 1, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 23, 59, 31, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 31, 0, 31, 0));
    pending_requests.push_back(make_req(datm_pkg::KIND_TICK, 31, 0, 31, 0));

    queue_random(430);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    sender_idle_pct = 72;
    queue_random(430);
    wait_drained();

    sender_idle_pct = 0;
    queue_random(440);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d requests under three idle mixes, checked %0d results", requests_sent,
             results_checked);
    $display("alarms fired %0d, full-table adds %0d, bad-index deletes %0d", alarms_fired,
             full_adds, bad_deletes);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
